>>> rtl/core/wlin_pkg.sv
package wlin_pkg;

	localparam int MAX_POINTS = 64;
	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [1:0] REG_BEFORE = 2'd0;
	localparam logic [1:0] REG_INSIDE = 2'd1;
	localparam logic [1:0] REG_AFTER  = 2'd2;

	localparam int NUM_W = 65;
	localparam int QUO_W = 49;

	typedef struct packed {
		logic [31:0] stamp;
		logic [31:0] z;
		logic [31:0] y;
		logic [31:0] x;
	} entry_t;

	typedef struct packed {
		logic start;
		logic wide;
	} div_cmd_t;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_FIRST  = 9'b000000010,
		ST_LAST   = 9'b000000100,
		ST_SEARCH = 9'b000001000,
		ST_SETUP  = 9'b000010000,
		ST_MUL    = 9'b000100000,
		ST_DIVGO  = 9'b001000000,
		ST_DIV    = 9'b010000000,
		ST_DONE   = 9'b100000000
	} state_t;

endpackage

>>> rtl/core/wlin_div.sv
module wlin_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  wlin_pkg::div_cmd_t          cmd,
	input  logic [wlin_pkg::NUM_W-1:0]  num,
	input  logic [31:0]                 den,
	output logic                        busy,
	output logic [wlin_pkg::QUO_W-1:0]  quo
);

	logic [31:0] rem_q;
	logic [wlin_pkg::QUO_W-1:0] sh_q;
	logic [wlin_pkg::QUO_W-1:0] quo_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [32:0] trial;
	logic [32:0] diff;
	logic ge;

	assign trial = {rem_q, sh_q[wlin_pkg::QUO_W-1]};
	assign ge = trial >= {1'b0, den};
	assign diff = trial - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			cnt_q <= cmd.wide ? 6'd49 : 6'd33;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Narrow mode starts from the upper dividend bits, which are known to be below the divisor.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			quo_q <= '0;
			if (cmd.wide) begin
				rem_q <= '0;
				sh_q <= num[wlin_pkg::QUO_W-1:0];
			end else begin
				rem_q <= num[64:33];
				sh_q <= {num[32:0], 16'b0};
			end
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : trial[31:0];
			sh_q <= {sh_q[wlin_pkg::QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[wlin_pkg::QUO_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo = quo_q;

	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q != 6'd0)) else $error("divider busy with zero count");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> busy_q) else $error("divider did not start");
	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q == 6'd1 && !cmd.start) |=> !busy_q) else $error("divider overran");

endmodule

>>> rtl/core/waypoint_linear_interpolator.sv
// Load transfers give no result.
// A query stops at the ends of the table once the first or last stamp is compared; inside it,
// one table read per cycle on the single memory port walks the segments, then a setup step,
// one multiply step and a 49-step bit-serial divide finish.
// One item is worked at a time; the result register lets a new transfer in while it waits.
// arst_n clears the control state and sets point_count to 1; table contents stay undefined.
module waypoint_linear_interpolator (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [6:0]   cfg_data,   // point_count
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [167:0] s_tdata,    // entry_index, load_x, load_y, load_z, load_stamp, query_time
	input  logic         s_tuser,    // command
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [199:0] m_tdata     // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, segment, region
);

	localparam int IW = wlin_pkg::IDX_W;

	wlin_pkg::state_t state_q;
	logic [6:0] pc_q;
	logic [IW-1:0] nm1;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] seg_q;
	logic [1:0] region_q;
	logic [31:0] t_q;
	wlin_pkg::entry_t p0_q;
	wlin_pkg::entry_t p1_q;
	wlin_pkg::entry_t mem_q [wlin_pkg::MAX_POINTS];
	wlin_pkg::entry_t rd_q;
	wlin_pkg::entry_t wr_entry;
	logic [IW-1:0] rd_addr;
	logic accept;
	logic mem_we;

	logic [32:0] a_s1 [3];
	logic neg_s1 [3];
	logic [31:0] u_s1;
	logic [31:0] dt_s1;
	logic [64:0] prod_s2 [3];
	logic [2:0] busy_pos;
	logic [2:0] busy_vel;
	logic [wlin_pkg::QUO_W-1:0] qpos [3];
	logic [wlin_pkg::QUO_W-1:0] qvel [3];
	wlin_pkg::div_cmd_t cmd_pos;
	wlin_pkg::div_cmd_t cmd_vel;
	logic [31:0] res_pos [3];
	logic [31:0] res_vel [3];
	logic [31:0] p0c [3];
	logic [31:0] p1c [3];
	logic out_free;

	always_comb begin
		if (pc_q == 7'd0) begin
			nm1 = '0;
		end else if (pc_q > 7'(wlin_pkg::MAX_POINTS)) begin
			nm1 = IW'(wlin_pkg::MAX_POINTS - 1);
		end else begin
			nm1 = IW'(pc_q - 7'd1);
		end
	end

	assign s_tready = (state_q == wlin_pkg::ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign mem_we = accept && (s_tuser == wlin_pkg::CMD_LOAD);
	assign out_free = !m_tvalid || m_tready;

	assign wr_entry.x = s_tdata[37:6];
	assign wr_entry.y = s_tdata[69:38];
	assign wr_entry.z = s_tdata[101:70];
	assign wr_entry.stamp = s_tdata[133:102];

	always_comb begin
		case (state_q)
			wlin_pkg::ST_FIRST:  rd_addr = nm1;
			wlin_pkg::ST_LAST:   rd_addr = IW'(1);
			wlin_pkg::ST_SEARCH: rd_addr = idx_q + IW'(2);
			default:             rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[s_tdata[IW-1:0]] <= wr_entry;
		end
		rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= 7'd1;
		end else if (cfg_we) begin
			pc_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wlin_pkg::ST_IDLE;
		end else begin
			case (state_q)
				wlin_pkg::ST_IDLE: begin
					if (accept && s_tuser == wlin_pkg::CMD_QUERY) begin
						state_q <= wlin_pkg::ST_FIRST;
					end
				end
				wlin_pkg::ST_FIRST: begin
					state_q <= (t_q <= rd_q.stamp) ? wlin_pkg::ST_DONE : wlin_pkg::ST_LAST;
				end
				wlin_pkg::ST_LAST: begin
					state_q <= (t_q >= rd_q.stamp) ? wlin_pkg::ST_DONE : wlin_pkg::ST_SEARCH;
				end
				wlin_pkg::ST_SEARCH: begin
					if (!(t_q > rd_q.stamp)) begin
						state_q <= wlin_pkg::ST_SETUP;
					end
				end
				wlin_pkg::ST_SETUP: state_q <= wlin_pkg::ST_MUL;
				wlin_pkg::ST_MUL:   state_q <= wlin_pkg::ST_DIVGO;
				wlin_pkg::ST_DIVGO: state_q <= wlin_pkg::ST_DIV;
				wlin_pkg::ST_DIV: begin
					if (busy_pos == 3'b000 && busy_vel == 3'b000) begin
						state_q <= wlin_pkg::ST_DONE;
					end
				end
				wlin_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= wlin_pkg::ST_IDLE;
					end
				end
				default: state_q <= wlin_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			wlin_pkg::ST_IDLE: begin
				t_q <= s_tdata[165:134];
				idx_q <= '0;
			end
			wlin_pkg::ST_FIRST: begin
				p0_q <= rd_q;
				seg_q <= '0;
				region_q <= wlin_pkg::REG_BEFORE;
			end
			wlin_pkg::ST_LAST: begin
				if (t_q >= rd_q.stamp) begin
					p0_q <= rd_q;
					seg_q <= nm1;
					region_q <= wlin_pkg::REG_AFTER;
				end else begin
					region_q <= wlin_pkg::REG_INSIDE;
				end
			end
			wlin_pkg::ST_SEARCH: begin
				// Walk forward while the time lies beyond the next stamp.
				if (t_q > rd_q.stamp) begin
					p0_q <= rd_q;
					idx_q <= idx_q + IW'(1);
				end else begin
					p1_q <= rd_q;
					seg_q <= idx_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign p0c[0] = p0_q.x;
	assign p0c[1] = p0_q.y;
	assign p0c[2] = p0_q.z;
	assign p1c[0] = p1_q.x;
	assign p1c[1] = p1_q.y;
	assign p1c[2] = p1_q.z;

	assign cmd_pos.start = (state_q == wlin_pkg::ST_DIVGO);
	assign cmd_pos.wide = 1'b0;
	assign cmd_vel.start = (state_q == wlin_pkg::ST_DIVGO);
	assign cmd_vel.wide = 1'b1;

	always_ff @(posedge clk) begin
		if (state_q == wlin_pkg::ST_SETUP) begin
			u_s1 <= t_q - p0_q.stamp;
			dt_s1 <= p1_q.stamp - p0_q.stamp;
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_axis
		logic [32:0] d;
		logic [63:0] lo;

		assign d = {p1c[g][31], p1c[g]} - {p0c[g][31], p0c[g]};
		assign lo = a_s1[g][31:0] * u_s1;

		always_ff @(posedge clk) begin
			if (state_q == wlin_pkg::ST_SETUP) begin
				neg_s1[g] <= d[32];
				a_s1[g] <= d[32] ? (33'd0 - d) : d;
			end
			if (state_q == wlin_pkg::ST_MUL) begin
				prod_s2[g] <= {1'b0, lo} + (a_s1[g][32] ? {1'b0, u_s1, 32'b0} : 65'd0);
			end
		end

		wlin_div u_div_pos (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd_pos),
			.num    (prod_s2[g]),
			.den    (dt_s1),
			.busy   (busy_pos[g]),
			.quo    (qpos[g])
		);

		wlin_div u_div_vel (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd_vel),
			.num    ({16'b0, a_s1[g], 16'b0}),
			.den    (dt_s1),
			.busy   (busy_vel[g]),
			.quo    (qvel[g])
		);

		always_comb begin
			if (region_q != wlin_pkg::REG_INSIDE) begin
				res_pos[g] = p0c[g];
				res_vel[g] = '0;
			end else if (neg_s1[g]) begin
				res_pos[g] = p0c[g] - qpos[g][31:0];
				res_vel[g] = (qvel[g] > 49'h0_0000_8000_0000) ? 32'h8000_0000
					: (32'd0 - qvel[g][31:0]);
			end else begin
				res_pos[g] = p0c[g] + qpos[g][31:0];
				res_vel[g] = (qvel[g] > 49'h0_0000_7FFF_FFFF) ? 32'h7FFF_FFFF
					: qvel[g][31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (state_q == wlin_pkg::ST_DONE && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == wlin_pkg::ST_DONE && out_free) begin
			m_tdata <= {region_q, seg_q, res_vel[2], res_vel[1], res_vel[0],
				res_pos[2], res_pos[1], res_pos[0]};
		end
	end

	a_inside_seg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wlin_pkg::ST_DONE && region_q == wlin_pkg::REG_INSIDE) |-> (seg_q < nm1))
		else $error("interior segment past last point");
	a_search_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wlin_pkg::ST_SEARCH) |-> ({1'b0, idx_q} < {1'b0, nm1}))
		else $error("segment search ran past the table");
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wlin_pkg::ST_DIVGO) |=> (busy_pos == 3'b111 && busy_vel == 3'b111))
		else $error("dividers not started together");
	a_query_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == wlin_pkg::CMD_QUERY) |=> (state_q == wlin_pkg::ST_FIRST))
		else $error("query transfer not started");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

	typedef struct packed {
		logic [1:0]  pad;
		logic [31:0] query_time;
		logic [31:0] stamp;
		logic [31:0] z;
		logic [31:0] y;
		logic [31:0] x;
		logic [5:0]  entry_index;
	} request_t;

	typedef struct packed {
		logic [1:0]  region;
		logic [5:0]  segment;
		logic [31:0] vel_z;
		logic [31:0] vel_y;
		logic [31:0] vel_x;
		logic [31:0] pos_z;
		logic [31:0] pos_y;
		logic [31:0] pos_x;
	} setpoint_t;

	typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_QUERY} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [6:0]  count;
		logic [5:0]  slot;
		logic [31:0] x, y, z, stamp, t;
		bit          typed;
		logic [1:0]  region;
		logic [5:0]  segment;
		logic [31:0] px, py, pz;
	} row_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [6:0]   cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [167:0] s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [199:0] m_tdata;

	waypoint_linear_interpolator u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// Shadow copy of the waypoint table and the point count.
	logic [31:0] wp_x [wlin_pkg::MAX_POINTS];
	logic [31:0] wp_y [wlin_pkg::MAX_POINTS];
	logic [31:0] wp_z [wlin_pkg::MAX_POINTS];
	logic [31:0] wp_t [wlin_pkg::MAX_POINTS];
	logic [6:0]  point_count;

	setpoint_t pending_setpoints[$];
	int        errors;
	int        items_sent;
	int        setpoints_checked;
	int        send_idle_pct;
	int        recv_stall_pct;
	bit        hold_request;
	int        hold_cycles;

	always #4 clk = ~clk;

	initial begin
		#20_000_000;
		$display("testbench: done, errors");
		$finish;
	end

	function automatic logic [31:0] lerp_axis(logic [31:0] p0, logic [31:0] p1,
			longint unsigned u, longint unsigned dt);
		longint          d;
		longint unsigned a, q, r, off;
		d = longint'($signed(p1)) - longint'($signed(p0));
		a = (d < 0) ? -d : d;
		q = a / dt;
		r = a % dt;
		off = q * u + (r * u) / dt;
		return (d < 0) ? p0 - off[31:0] : p0 + off[31:0];
	endfunction

	function automatic logic [31:0] velocity_axis(logic [31:0] p0, logic [31:0] p1,
			longint unsigned dt);
		longint          d;
		longint unsigned a, v;
		d = longint'($signed(p1)) - longint'($signed(p0));
		a = (d < 0) ? -d : d;
		v = (a << 16) / dt;
		if (d < 0) begin
			if (v > 64'h8000_0000)
				v = 64'h8000_0000;
			return -v[31:0];
		end
		if (v > 64'h7fff_ffff)
			v = 64'h7fff_ffff;
		return v[31:0];
	endfunction

	function automatic setpoint_t interpolate(logic [31:0] t);
		setpoint_t       sp;
		int              n, i;
		longint unsigned u, dt;
		n = (point_count == 0) ? 1 : (point_count > wlin_pkg::MAX_POINTS) ?
			wlin_pkg::MAX_POINTS : point_count;
		sp = '0;
		if (t <= wp_t[0] || t >= wp_t[n-1]) begin
			i = (t <= wp_t[0]) ? 0 : n - 1;
			sp.region = (t <= wp_t[0]) ? wlin_pkg::REG_BEFORE : wlin_pkg::REG_AFTER;
			sp.segment = i[5:0];
			sp.pos_x = wp_x[i];
			sp.pos_y = wp_y[i];
			sp.pos_z = wp_z[i];
			return sp;
		end
		i = 0;
		while (i + 1 < n && t > wp_t[i+1])
			i++;
		u = t - wp_t[i];
		dt = wp_t[i+1] - wp_t[i];
		sp.region = wlin_pkg::REG_INSIDE;
		sp.segment = i[5:0];
		sp.pos_x = lerp_axis(wp_x[i], wp_x[i+1], u, dt);
		sp.pos_y = lerp_axis(wp_y[i], wp_y[i+1], u, dt);
		sp.pos_z = lerp_axis(wp_z[i], wp_z[i+1], u, dt);
		sp.vel_x = velocity_axis(wp_x[i], wp_x[i+1], dt);
		sp.vel_y = velocity_axis(wp_y[i], wp_y[i+1], dt);
		sp.vel_z = velocity_axis(wp_z[i], wp_z[i+1], dt);
		return sp;
	endfunction

	// Offers one item and returns at the clock edge of its transfer. A load updates
	// the shadow table there; a query queues its setpoint, typed in or predicted.
	task automatic send_item(logic cmd, request_t req, bit typed, setpoint_t typed_sp);
		bit accepted;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= req;
		do begin
			@(negedge clk);
			accepted = s_tready;
			@(posedge clk);
		end while (!accepted);
		items_sent++;
		if (cmd == wlin_pkg::CMD_LOAD) begin
			wp_x[req.entry_index] = req.x;
			wp_y[req.entry_index] = req.y;
			wp_z[req.entry_index] = req.z;
			wp_t[req.entry_index] = req.stamp;
		end else
			pending_setpoints.insert(pending_setpoints.size(),
				typed ? typed_sp : interpolate(req.query_time));
	endtask

	// Called at the edge of the last transfer, so the valid drop is the only update there.
	task automatic write_point_count(logic [6:0] value);
		s_tvalid <= 1'b0;
		wait (pending_setpoints.size() == 0);
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		point_count = value;
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (hold_request) begin
			hold_request <= 1'b0;
			hold_cycles <= 600;
			m_tready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Inputs only change at rising edges, so what is seen here is what transfers next.
	always @(negedge clk) begin
		setpoint_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_setpoints.size() == 0) begin
				$display("%0t: unexpected setpoint, actual %h", $time, m_tdata);
				errors++;
			end else begin
				want = pending_setpoints.pop_front();
				check_field("pos_x", want.pos_x, got.pos_x);
				check_field("pos_y", want.pos_y, got.pos_y);
				check_field("pos_z", want.pos_z, got.pos_z);
				check_field("vel_x", want.vel_x, got.vel_x);
				check_field("vel_y", want.vel_y, got.vel_y);
				check_field("vel_z", want.vel_z, got.vel_z);
				check_field("segment", 32'(want.segment), 32'(got.segment));
				check_field("region", 32'(want.region), 32'(got.region));
				setpoints_checked++;
			end
		end
	end

	function automatic logic [31:0] random_coord();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	row_t rows[$];

	function automatic row_t make_row(row_kind_t kind, logic [6:0] count, logic [5:0] slot,
			logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] stamp,
			logic [31:0] t, bit typed, logic [1:0] region, logic [5:0] segment,
			logic [31:0] px, logic [31:0] py, logic [31:0] pz);
		row_t r;
		r.kind = kind; r.count = count; r.slot = slot;
		r.x = x; r.y = y; r.z = z; r.stamp = stamp; r.t = t;
		r.typed = typed; r.region = region; r.segment = segment;
		r.px = px; r.py = py; r.pz = pz;
		return r;
	endfunction

	initial begin
		request_t    req;
		setpoint_t   sp;
		int          n, k, phase, slot_hi, lo, hi;
		logic [31:0] stamp, step_max;
		logic [6:0]  counts [7];

		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = wlin_pkg::CMD_LOAD;
		m_tready = 1'b0;
		hold_request = 1'b0;
		hold_cycles = 0;
		errors = 0;
		items_sent = 0;
		setpoints_checked = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		point_count = 7'd1;
		for (int i = 0; i < wlin_pkg::MAX_POINTS; i++) begin
			wp_x[i] = '0; wp_y[i] = '0; wp_z[i] = '0; wp_t[i] = '0;
		end

		// Directed part: a single point at reset, a count of zero, then a short
		// table with a one-tick segment, an interior stamp hit and a stamp that goes back.
		rows.insert(rows.size(), make_row(ROW_LOAD, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 0,
			32'h1_0000, 0, 0, 0, 0, 0, 0, 0));
		rows.insert(rows.size(), make_row(ROW_QUERY, 0, 0, 0, 0, 0, 0, 32'h0, 1,
			wlin_pkg::REG_BEFORE, 0, 32'h7fff_ffff, 32'h8000_0000, 0));
		rows.insert(rows.size(), make_row(ROW_QUERY, 0, 0, 0, 0, 0, 0, 32'h1_0000, 1,
			wlin_pkg::REG_BEFORE, 0, 32'h7fff_ffff, 32'h8000_0000, 0));
		rows.insert(rows.size(), make_row(ROW_QUERY, 0, 0, 0, 0, 0, 0, 32'hffff_ffff, 1,
			wlin_pkg::REG_AFTER, 0, 32'h7fff_ffff, 32'h8000_0000, 0));
		rows.insert(rows.size(), make_row(ROW_CFG, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		rows.insert(rows.size(), make_row(ROW_QUERY, 0, 0, 0, 0, 0, 0, 32'h2_0000, 1,
			wlin_pkg::REG_AFTER, 0, 32'h7fff_ffff, 32'h8000_0000, 0));
		rows.insert(rows.size(), make_row(ROW_CFG, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		rows.insert(rows.size(), make_row(ROW_LOAD, 0, 1, 32'h8000_0000, 32'h7fff_ffff,
			32'h100, 32'h2_0000, 0, 0, 0, 0, 0, 0, 0));
		rows.insert(rows.size(), make_row(ROW_LOAD, 0, 2, 32'h7fff_ffff, 32'h8000_0000,
			32'hffff_ff00, 32'h2_0001, 0, 0, 0, 0, 0, 0, 0));
		rows.insert(rows.size(), make_row(ROW_QUERY, 0, 0, 0, 0, 0, 0, 32'h1_8000, 0, 0, 0,
			0, 0, 0));
		rows.insert(rows.size(), make_row(ROW_QUERY, 0, 0, 0, 0, 0, 0, 32'h2_0000, 0, 0, 0,
			0, 0, 0));
		rows.insert(rows.size(), make_row(ROW_QUERY, 0, 0, 0, 0, 0, 0, 32'h1_0001, 0, 0, 0,
			0, 0, 0));
		rows.insert(rows.size(), make_row(ROW_QUERY, 0, 0, 0, 0, 0, 0, 32'h2_0001, 1,
			wlin_pkg::REG_AFTER, 2, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ff00));
		rows.insert(rows.size(), make_row(ROW_LOAD, 0, 63, 32'h1234_5678, 32'h8765_4321,
			32'h0f0f_0f0f, 32'h0, 0, 0, 0, 0, 0, 0, 0));
		rows.insert(rows.size(), make_row(ROW_LOAD, 0, 2, 32'h8000_0000, 32'h7fff_ffff, 32'h0,
			32'hffff_ffff, 0, 0, 0, 0, 0, 0, 0));
		rows.insert(rows.size(), make_row(ROW_QUERY, 0, 0, 0, 0, 0, 0, 32'hffff_fffe, 0, 0, 0,
			0, 0, 0));
		rows.insert(rows.size(), make_row(ROW_LOAD, 0, 1, 32'h0, 32'h0, 32'h0, 32'h0,
			0, 0, 0, 0, 0, 0, 0));
		rows.insert(rows.size(), make_row(ROW_QUERY, 0, 0, 0, 0, 0, 0, 32'h1_8000, 0, 0, 0,
			0, 0, 0));
		rows.insert(rows.size(), make_row(ROW_CFG, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		rows.insert(rows.size(), make_row(ROW_QUERY, 0, 0, 0, 0, 0, 0, 32'h1_8000, 0, 0, 0,
			0, 0, 0));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[r]) begin
			if (rows[r].kind == ROW_CFG)
				write_point_count(rows[r].count);
			else begin
				req = '0;
				req.entry_index = rows[r].slot;
				req.x = rows[r].x;
				req.y = rows[r].y;
				req.z = rows[r].z;
				req.stamp = rows[r].stamp;
				req.query_time = rows[r].t;
				sp = '0;
				sp.region = rows[r].region;
				sp.segment = rows[r].segment;
				sp.pos_x = rows[r].px;
				sp.pos_y = rows[r].py;
				sp.pos_z = rows[r].pz;
				send_item(rows[r].kind == ROW_QUERY ? wlin_pkg::CMD_QUERY : wlin_pkg::CMD_LOAD,
					req, rows[r].typed, sp);
			end
		end

		// Random part: each phase sets a count, fills the slots in use with rising
		// stamps, then mixes queries with loads that may break the ordering.
		counts = '{7'd2, 7'd64, 7'd127, 7'd0, 7'd1, 7'($urandom_range(3, 20)), 7'd33};
		for (phase = 0; phase < 7; phase++) begin
			write_point_count(counts[phase]);
			send_idle_pct = (phase % 4 == 1 || phase % 4 == 3) ? ((phase % 4 == 1) ? 63 : 28) : 0;
			recv_stall_pct = (phase % 4 == 2 || phase % 4 == 3) ? ((phase % 4 == 2) ? 63 : 28) : 0;
			n = (counts[phase] == 0) ? 1 : (counts[phase] > wlin_pkg::MAX_POINTS) ?
				wlin_pkg::MAX_POINTS : counts[phase];
			step_max = ($urandom_range(2) == 0) ? 32'd3 : ($urandom_range(1) ? 32'h3f_ffff : 32'hfff);
			stamp = $urandom_range(0, 32'h10_0000);
			for (k = 0; k < n; k++) begin
				req = '0;
				req.entry_index = 6'(k);
				req.x = random_coord();
				req.y = random_coord();
				req.z = random_coord();
				req.stamp = stamp;
				req.query_time = $urandom;
				send_item(wlin_pkg::CMD_LOAD, req, 0, '0);
				stamp = stamp + $urandom_range(1, step_max);
			end
			if (phase == 0)
				hold_request = 1'b1;
			for (k = 0; k < 222; k++) begin
				req = '0;
				req.x = random_coord();
				req.y = random_coord();
				req.z = random_coord();
				req.stamp = $urandom;
				req.entry_index = 6'($urandom_range(0, wlin_pkg::MAX_POINTS - 1));
				req.query_time = $urandom;
				if ($urandom_range(99) < 12) begin
					// Now and then reload a slot in use with an in-order stamp.
					if ($urandom_range(1) && n > 1) begin
						slot_hi = $urandom_range(0, n - 1);
						req.entry_index = 6'(slot_hi);
						req.stamp = wp_t[slot_hi];
					end
					send_item(wlin_pkg::CMD_LOAD, req, 0, '0);
				end else begin
					lo = $urandom_range(0, n - 1);
					case ($urandom_range(9))
						0: req.query_time = wp_t[lo];
						1: req.query_time = wp_t[lo] + 1;
						2: req.query_time = wp_t[lo] - 1;
						3: req.query_time = $urandom_range(1) ? 32'h0 : 32'hffff_ffff;
						4: req.query_time = $urandom;
						default: begin
							hi = $urandom_range(0, n - 1);
							req.query_time = (wp_t[lo] <= wp_t[hi]) ?
								$urandom_range(wp_t[lo], wp_t[hi]) :
								$urandom_range(wp_t[hi], wp_t[lo]);
						end
					endcase
					send_item(wlin_pkg::CMD_QUERY, req, 0, '0);
				end
			end
		end

		s_tvalid <= 1'b0;
		wait (pending_setpoints.size() == 0);
		repeat (150) @(posedge clk);
		$display("testbench: %0d transfers in, %0d setpoints checked over 7 table settings",
			items_sent, setpoints_checked);
		$display("testbench: counts 0, 1, 2, 33, 64 and 127 with idle and stall mixes");
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

>>> waypoint_linear_interpolator.f
rtl/core/wlin_pkg.sv
rtl/core/wlin_div.sv
rtl/core/waypoint_linear_interpolator.sv
verif/testbench.sv
